// ===== src/bvt_pkg.sv =====
package bvt_pkg;

  // Fixed widths of the transaction fields
  localparam int unsigned OP_W  = 3;
  localparam int unsigned POS_W = 5;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned CNT_W = 5;

  // Operation codes
  typedef enum logic [OP_W-1:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_GET    = 3'd2,
    OP_SET    = 3'd3,
    OP_INSERT = 3'd4,
    OP_REMOVE = 3'd5,
    OP_CLEAR  = 3'd6
  } op_e;

  // Broadcast command from the controller to every cell
  typedef struct packed {
    logic load;        // write the word into the cell at the target index
    logic shift_up;    // cells above the target take their lower neighbor
    logic shift_down;  // cells at or above the target take their upper neighbor
  } cmd_t;

endpackage

// ===== src/bvt_if.sv =====
interface bvt_req_if;
  logic                       valid;
  logic                       ready;
  logic [bvt_pkg::OP_W-1:0]   opcode;
  logic [bvt_pkg::POS_W-1:0]  position;
  logic [bvt_pkg::VAL_W-1:0]  value;

  modport source (output valid, output opcode, output position, output value, input ready);
  modport sink   (input valid, input opcode, input position, input value, output ready);
endinterface

interface bvt_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       ok;
  logic [bvt_pkg::VAL_W-1:0]  read_value;
  logic [bvt_pkg::CNT_W-1:0]  count;

  modport source (output valid, output ok, output read_value, output count, input ready);
  modport sink   (input valid, input ok, input read_value, input count, output ready);
endinterface

// ===== src/bvt_cell.sv =====
module bvt_cell #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned CW    = 5,
  parameter int unsigned WIDTH = 32
) (
  input  logic               clk_i,
  input  bvt_pkg::cmd_t      cmd_i,
  input  logic [CW-1:0]      target_i,
  input  logic [WIDTH-1:0]   word_i,
  input  logic [WIDTH-1:0]   left_i,
  input  logic [WIDTH-1:0]   right_i,
  output logic [WIDTH-1:0]   data_o
);
  import bvt_pkg::*;

  localparam logic [CW-1:0] MyIdx = CW'(IDX);

  logic             at_target;
  logic             above_target;
  logic [WIDTH-1:0] data_q;

  assign at_target    = (target_i == MyIdx);
  assign above_target = (MyIdx > target_i);

  // Shift from a neighbor or load the new word
  always_ff @(posedge clk_i) begin
    if (cmd_i.shift_up && above_target) begin
      data_q <= left_i;
    end else if (cmd_i.load && at_target) begin
      data_q <= word_i;
    end else if (cmd_i.shift_down && (above_target || at_target)) begin
      data_q <= right_i;
    end
  end

  assign data_o = data_q;

endmodule

// ===== src/bvt_ctrl.sv =====
module bvt_ctrl #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned CW    = 5
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  bvt_req_if.sink                     req,
  bvt_rsp_if.source                   rsp,
  input  logic [bvt_pkg::VAL_W-1:0]   rd_word_i,
  output bvt_pkg::cmd_t               cmd_o,
  output logic [CW-1:0]               target_o
);
  import bvt_pkg::*;

  localparam int unsigned CMP_W = (CW > POS_W) ? CW : POS_W;
  localparam logic [CW-1:0] Full = CW'(DEPTH);

  op_e              op;
  logic             accept;
  logic             ok;
  logic             is_full;
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] fill_ext;
  logic [CW-1:0]    fill_d;
  logic [CW-1:0]    fill_q;
  logic             rsp_valid_q;
  logic             ok_q;
  logic [VAL_W-1:0] rd_q;
  logic [CNT_W-1:0] cnt_q;

  assign op       = op_e'(req.opcode);
  assign accept   = req.valid && req.ready;
  assign is_full  = (fill_q == Full);
  assign pos_ext  = CMP_W'(req.position);
  assign fill_ext = CMP_W'(fill_q);

  // Accept whenever the result register is free or being drained
  assign req.ready = !rsp_valid_q || rsp.ready;

  // Decode the operation, check bounds, build the cell command
  always_comb begin
    ok       = 1'b0;
    fill_d   = fill_q;
    cmd_o    = '0;
    target_o = CW'(req.position);
    unique case (op)
      OP_PUSH: begin
        ok       = !is_full;
        target_o = fill_q;
        cmd_o.load = ok;
        if (ok) fill_d = fill_q + CW'(1);
      end
      OP_POP: begin
        ok = (fill_q != '0);
        if (ok) fill_d = fill_q - CW'(1);
      end
      OP_GET: begin
        ok = (pos_ext < fill_ext);
      end
      OP_SET: begin
        ok         = (pos_ext < fill_ext);
        cmd_o.load = ok;
      end
      OP_INSERT: begin
        ok             = (pos_ext <= fill_ext) && !is_full;
        cmd_o.load     = ok;
        cmd_o.shift_up = ok;
        if (ok) fill_d = fill_q + CW'(1);
      end
      OP_REMOVE: begin
        ok               = (pos_ext < fill_ext);
        cmd_o.shift_down = ok;
        if (ok) fill_d = fill_q - CW'(1);
      end
      OP_CLEAR: begin
        ok     = 1'b1;
        fill_d = '0;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
    // Drop every effect unless the transaction is taken
    if (!accept) begin
      cmd_o  = '0;
      fill_d = fill_q;
    end
  end

  // Element count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  // Result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (accept) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  // Result payload, held while the sink stalls
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ok_q  <= ok;
      rd_q  <= (op == OP_GET && ok) ? rd_word_i : '0;
      cnt_q <= CNT_W'(fill_d);
    end
  end

  assign rsp.valid      = rsp_valid_q;
  assign rsp.ok         = ok_q;
  assign rsp.read_value = rd_q;
  assign rsp.count      = cnt_q;

  // Checks
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= Full) else $error("fill above depth");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && !rsp.ready) |-> !accept) else $error("pending result overwritten");

  a_clear_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && op == OP_CLEAR) |=> (fill_q == '0 && rsp.ok && rsp.valid))
    else $error("clear left elements");

  a_fail_keeps_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !ok) |=> $stable(fill_q)) else $error("failed operation changed fill");

  a_read_only_get: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && op != OP_GET) |=> (rsp.read_value == '0))
    else $error("read value outside get");

endmodule

// ===== src/bounded_vector_table.sv =====
// Bounded vector of DEPTH words of WIDTH bits held in a row of cells, one word per cell,
// each cell loading the new word or its lower or upper neighbor, so insert and remove shift
// every element from the position upward in parallel. A transaction accepted on req_i
// gives its result on rsp_o on the next cycle from a result register, and req_i.ready
// stays high unless a result is waiting and rsp_o.ready is low, so one transaction per
// cycle is sustained. Get reads through a position-selected mux over the first
// min(DEPTH, 32) cells, the reach of the 5-bit position field, which also limits set,
// insert and remove to those indices. Count reports the low 5 bits of the element count.
// Element contents are not reset; only the count and result valid flag are. Words are
// kept in their low WIDTH bits and read back zero-extended or truncated to 32 bits.
module bounded_vector_table #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bvt_req_if.sink     req_i,
  bvt_rsp_if.source   rsp_o
);
  import bvt_pkg::*;

  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned RD_N = (DEPTH < 32) ? DEPTH : 32;

  cmd_t             cmd;
  logic [CW-1:0]    target;
  logic [WIDTH-1:0] word;
  logic [WIDTH-1:0] cell_data [DEPTH];
  logic [VAL_W-1:0] rd_word;

  assign word = WIDTH'(req_i.value);

  bvt_ctrl #(
    .DEPTH (DEPTH),
    .CW    (CW)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req       (req_i),
    .rsp       (rsp_o),
    .rd_word_i (rd_word),
    .cmd_o     (cmd),
    .target_o  (target)
  );

  // Row of element cells, each linked to its neighbors; below the first is the new word, above the last is itself
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WIDTH-1:0] left;
    logic [WIDTH-1:0] right;

    if (i == 0) begin : g_first
      assign left = word;
    end else begin : g_mid_l
      assign left = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right = cell_data[i];
    end else begin : g_mid_r
      assign right = cell_data[i+1];
    end

    bvt_cell #(
      .IDX   (i),
      .CW    (CW),
      .WIDTH (WIDTH)
    ) u_cell (
      .clk_i    (clk_i),
      .cmd_i    (cmd),
      .target_i (target),
      .word_i   (word),
      .left_i   (left),
      .right_i  (right),
      .data_o   (cell_data[i])
    );
  end

  // Select the cell addressed by position for get
  always_comb begin
    rd_word = '0;
    for (int unsigned k = 0; k < RD_N; k++) begin
      if (req_i.position == POS_W'(k)) begin
        rd_word = VAL_W'(cell_data[k]);
      end
    end
  end

endmodule
